// ===== hw/rtl/mte_pkg.sv =====
// ----------------------------------------------------------------------------
// mte_pkg
// shared types, command codes and the sine table builder of the 4x4 transform
// engine
// ----------------------------------------------------------------------------
package mte_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_WORD_BITS = 32;
    localparam int SIN_BITS      = 25;
    localparam int QUAD_LAST     = 90;

    typedef enum logic [2:0] {
        OP_IDENT      = 3'd0,
        OP_WRITE_CUR  = 3'd1,
        OP_READ_CUR   = 3'd2,
        OP_TRANSLATE  = 3'd3,
        OP_SCALE      = 3'd4,
        OP_ROTATE     = 3'd5,
        OP_WRITE_OPND = 3'd6,
        OP_MULTIPLY   = 3'd7
    } op_t;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_BAD = 2'd3;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_RDATA,
        ST_MUL,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [1:0]         rot_axis;
        logic [8:0]         angle_degrees;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               status;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [3:0] addr;
    } mac_tag_t;

    typedef logic [SIN_BITS-1:0] sin_tab_t [0:QUAD_LAST];

    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

    // sine of 0..90 degrees by a q61 taylor series, rounded to frac bits
    function automatic sin_tab_t build_sin_tab(input int frac);
        sin_tab_t     tab;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  s;
        logic [127:0] pr;
        logic [63:0]  d64;
        for (int d = 0; d <= QUAD_LAST; d++) begin
            d64  = 64'(d);
            x    = (PI_Q61 / 64'd180) * d64 + ((PI_Q61 % 64'd180) * d64) / 64'd180;
            pr   = {64'd0, x} * {64'd0, x};
            x2   = pr[124:61];
            term = x;
            s    = x;
            for (int k = 2; k < 40; k += 2) begin
                pr   = {64'd0, term} * {64'd0, x2};
                term = pr[124:61] / 64'(k * (k + 1));
                if ((k & 2) != 0) begin
                    s = s - term;
                end else begin
                    s = s + term;
                end
            end
            s      = (s + (64'd1 << (60 - frac))) >> (61 - frac);
            tab[d] = SIN_BITS'(s);
        end
        return tab;
    endfunction

endpackage

// ===== hw/rtl/mte_trig.sv =====
// ----------------------------------------------------------------------------
// mte_trig
// sine and cosine of a whole-degree angle from a quadrant table
// ----------------------------------------------------------------------------
module mte_trig import mte_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic [8:0]                  angle,
    output logic signed [WORD_BITS-1:0] sin_val,
    output logic signed [WORD_BITS-1:0] cos_val
);

    localparam sin_tab_t    SIN_TAB = build_sin_tab(FRAC_BITS);
    localparam logic [63:0] WMAX    = (64'd1 << (WORD_BITS - 1)) - 64'd1;

    logic [8:0] ang_mod;
    logic [9:0] ang_cos_wide;
    logic [8:0] ang_cos;

    // returns {negate, quadrant angle}
    function automatic logic [7:0] quad(input logic [8:0] a);
        logic       neg;
        logic [8:0] d;
        if (a <= 9'd90) begin
            neg = 1'b0;
            d   = a;
        end else if (a <= 9'd180) begin
            neg = 1'b0;
            d   = 9'd180 - a;
        end else if (a <= 9'd270) begin
            neg = 1'b1;
            d   = a - 9'd180;
        end else begin
            neg = 1'b1;
            d   = 9'd360 - a;
        end
        return {neg, d[6:0]};
    endfunction

    function automatic logic signed [WORD_BITS-1:0] lookup(input logic [7:0] q);
        logic [63:0]                  mag;
        logic signed [WORD_BITS-1:0]  v;
        mag = 64'(SIN_TAB[q[6:0]]);
        if (mag > WMAX) begin
            mag = WMAX;
        end
        v = WORD_BITS'(mag);
        return q[7] ? -v : v;
    endfunction

    always_comb begin
        ang_mod      = (angle >= 9'd360) ? angle - 9'd360 : angle;
        ang_cos_wide = {1'b0, ang_mod} + 10'd90;
        ang_cos      = (ang_cos_wide >= 10'd360) ? 9'(ang_cos_wide - 10'd360)
                                                 : ang_cos_wide[8:0];
        sin_val      = lookup(quad(ang_mod));
        cos_val      = lookup(quad(ang_cos));
    end

endmodule

// ===== hw/rtl/mte_mac.sv =====
// ----------------------------------------------------------------------------
// mte_mac
// multiply-accumulate over four products, then shift and saturate
// ----------------------------------------------------------------------------
module mte_mac import mte_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mac_tag_t                    in_tag,
    input  logic signed [WORD_BITS-1:0] in_a,
    input  logic signed [WORD_BITS-1:0] in_b,
    output logic                        wr_valid,
    output logic [3:0]                  wr_addr,
    output logic signed [WORD_BITS-1:0] wr_data,
    output logic                        busy
);

    localparam int PW = 2 * WORD_BITS;
    localparam int AW = PW + 2;

    mac_tag_t                    ptag_reg;
    logic signed [PW-1:0]        prod_reg;
    logic signed [AW-1:0]        acc_reg;
    logic signed [AW-1:0]        acc_next;
    logic signed [AW-1:0]        shifted;
    logic                        in_range;
    logic signed [WORD_BITS-1:0] sat_val;
    logic                        wr_valid_reg;
    logic [3:0]                  wr_addr_reg;
    logic signed [WORD_BITS-1:0] wr_data_reg;

    always_comb begin
        acc_next = (ptag_reg.first ? '0 : acc_reg) + AW'(prod_reg);
        shifted  = acc_next >>> FRAC_BITS;
        in_range = (&shifted[AW-1:WORD_BITS-1]) || !(|shifted[AW-1:WORD_BITS-1]);
        if (in_range) begin
            sat_val = WORD_BITS'(shifted);
        end else if (shifted[AW-1]) begin
            sat_val = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PW'(in_a) * PW'(in_b);
        if (ptag_reg.valid) begin
            acc_reg <= acc_next;
        end
        wr_addr_reg <= ptag_reg.addr;
        wr_data_reg <= sat_val;
        if (!aresetn) begin
            ptag_reg     <= '0;
            wr_valid_reg <= 1'b0;
        end else begin
            ptag_reg     <= in_tag;
            wr_valid_reg <= ptag_reg.valid && ptag_reg.last;
        end
    end

    assign wr_valid = wr_valid_reg;
    assign wr_addr  = wr_addr_reg;
    assign wr_data  = wr_data_reg;
    assign busy     = in_tag.valid || ptag_reg.valid || wr_valid_reg;

endmodule

// ===== hw/rtl/matrix4_transform_engine.sv =====
// ----------------------------------------------------------------------------
// matrix4_transform_engine
// 4x4 fixed-point transform unit: current and operand matrices in memory,
// premultiply by operand, translation, scale or rotation
// ----------------------------------------------------------------------------
// One command item is taken at a time and gives one result item. Translate,
// scale, rotate (about a valid axis) and multiply premultiply: they issue 64
// multiply-accumulates through a single multiplier, one memory read of each
// matrix per cycle, and drain the multiply-accumulate pipeline. The current
// matrix sits in two banks of one memory; a premultiply reads one bank and
// writes the other, then swaps them. After reset a pass loads identity and
// clears the operand matrix before the first item is taken. A finished result
// waits in an output register while the next item is taken.
// ----------------------------------------------------------------------------
module matrix4_transform_engine import mte_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int W = WORD_BITS;
    localparam logic signed [W-1:0] ONE =
        (FRAC_BITS >= W - 1) ? {1'b0, {(W-1){1'b1}}} : W'(64'd1 << FRAC_BITS);

    logic signed [W-1:0] cur_mem [0:31];
    logic signed [W-1:0] opnd_mem [0:15];

    state_t              state_reg, state_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                bank_reg, bank_next;
    logic                init_reg, init_next;
    in_item_t            cmd_reg, cmd_next;
    logic signed [31:0]  res_value_reg, res_value_next;
    logic                res_status_reg, res_status_next;
    out_item_t           out_reg, out_next;
    logic                m_valid_reg, m_valid_next;
    mac_tag_t            iss_reg, iss_next;
    logic signed [W-1:0] mval_reg, mval_next;

    logic                cur_we;
    logic [4:0]          cur_waddr;
    logic signed [W-1:0] cur_wdata;
    logic [4:0]          cur_raddr;
    logic signed [W-1:0] cur_rdata_reg;
    logic                opnd_we;
    logic [3:0]          opnd_waddr;
    logic signed [W-1:0] opnd_wdata;
    logic [3:0]          opnd_raddr;
    logic signed [W-1:0] opnd_rdata_reg;

    logic signed [W-1:0] sin_val, cos_val;
    logic signed [W-1:0] cx, cy, cz;
    logic [3:0]          midx;
    logic signed [W-1:0] mac_a;
    logic                wr_valid, mac_busy;
    logic [3:0]          wr_addr;
    logic signed [W-1:0] wr_data;
    logic signed [63:0]  rd_ext;

    function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        if ((&x[63:W-1]) || !(|x[63:W-1])) begin
            return W'(x);
        end else if (x[63]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [W-1:0] ident(input logic [3:0] i);
        return (i inside {4'd0, 4'd5, 4'd10, 4'd15}) ? ONE : '0;
    endfunction

    mte_trig #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_trig (
        .angle   (cmd_reg.angle_degrees),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    assign mac_a = (op_t'(cmd_reg.op) == OP_MULTIPLY) ? opnd_rdata_reg : mval_reg;

    mte_mac #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (iss_reg),
        .in_a     (mac_a),
        .in_b     (cur_rdata_reg),
        .wr_valid (wr_valid),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .busy     (mac_busy)
    );

    // transform element for row/col midx
    always_comb begin
        cx        = sat_in(cmd_reg.coord_x);
        cy        = sat_in(cmd_reg.coord_y);
        cz        = sat_in(cmd_reg.coord_z);
        midx      = {cnt_reg[5:4], cnt_reg[1:0]};
        mval_next = ident(midx);
        case (op_t'(cmd_reg.op))
            OP_TRANSLATE: begin
                if (midx == 4'd12) mval_next = cx;
                if (midx == 4'd13) mval_next = cy;
                if (midx == 4'd14) mval_next = cz;
            end
            OP_SCALE: begin
                if (midx == 4'd0)  mval_next = cx;
                if (midx == 4'd5)  mval_next = cy;
                if (midx == 4'd10) mval_next = cz;
            end
            OP_ROTATE: begin
                case (cmd_reg.rot_axis)
                    AXIS_X: begin
                        if (midx == 4'd5 || midx == 4'd10) mval_next = cos_val;
                        if (midx == 4'd6) mval_next = -sin_val;
                        if (midx == 4'd9) mval_next = sin_val;
                    end
                    AXIS_Y: begin
                        if (midx == 4'd0 || midx == 4'd10) mval_next = cos_val;
                        if (midx == 4'd2) mval_next = sin_val;
                        if (midx == 4'd8) mval_next = -sin_val;
                    end
                    default: begin
                        if (midx == 4'd0 || midx == 4'd5) mval_next = cos_val;
                        if (midx == 4'd1) mval_next = -sin_val;
                        if (midx == 4'd4) mval_next = sin_val;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        bank_next       = bank_reg;
        init_next       = init_reg;
        cmd_next        = cmd_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        iss_next        = '0;
        s_ready         = 1'b0;
        cur_we          = 1'b0;
        cur_waddr       = {bank_reg, cnt_reg[3:0]};
        cur_wdata       = ident(cnt_reg[3:0]);
        cur_raddr       = {bank_reg, cmd_reg.elem_index};
        opnd_we         = 1'b0;
        opnd_waddr      = cnt_reg[3:0];
        opnd_wdata      = '0;
        opnd_raddr      = {cnt_reg[5:4], cnt_reg[1:0]};
        rd_ext          = 64'(cur_rdata_reg);

        case (state_reg)
            ST_FILL: begin
                cur_we   = 1'b1;
                opnd_we  = init_reg;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[3:0] == 4'hF) begin
                    cnt_next   = '0;
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next        = s_item;
                    cnt_next        = '0;
                    res_value_next  = '0;
                    res_status_next = 1'b0;
                    case (op_t'(s_item.op))
                        OP_IDENT: state_next = ST_FILL;
                        OP_WRITE_CUR: begin
                            cur_we     = 1'b1;
                            cur_waddr  = {bank_reg, s_item.elem_index};
                            cur_wdata  = sat_in(s_item.elem_value);
                            state_next = ST_DONE;
                        end
                        OP_READ_CUR: state_next = ST_READ;
                        OP_ROTATE: begin
                            if (s_item.rot_axis == AXIS_BAD) begin
                                res_status_next = 1'b1;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_MUL;
                            end
                        end
                        OP_WRITE_OPND: begin
                            opnd_we    = 1'b1;
                            opnd_waddr = s_item.elem_index;
                            opnd_wdata = sat_in(s_item.elem_value);
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_MUL;
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                if ((&rd_ext[63:31]) || !(|rd_ext[63:31])) begin
                    res_value_next = 32'(rd_ext);
                end else if (rd_ext[63]) begin
                    res_value_next = {1'b1, {31{1'b0}}};
                end else begin
                    res_value_next = {1'b0, {31{1'b1}}};
                end
                state_next = ST_DONE;
            end
            ST_MUL: begin
                cur_raddr      = {bank_reg, cnt_reg[1:0], cnt_reg[3:2]};
                iss_next.valid = 1'b1;
                iss_next.first = (cnt_reg[1:0] == 2'd0);
                iss_next.last  = (cnt_reg[1:0] == 2'd3);
                iss_next.addr  = cnt_reg[5:2];
                cnt_next       = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!iss_reg.valid && !mac_busy) begin
                    bank_next  = !bank_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.read_value = res_value_reg;
                    out_next.status     = res_status_reg;
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (wr_valid) begin
            cur_we    = 1'b1;
            cur_waddr = {!bank_reg, wr_addr};
            cur_wdata = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        cur_rdata_reg <= cur_mem[cur_raddr];
        if (opnd_we) begin
            opnd_mem[opnd_waddr] <= opnd_wdata;
        end
        opnd_rdata_reg <= opnd_mem[opnd_raddr];
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
        mval_reg       <= mval_next;
        if (!aresetn) begin
            state_reg   <= ST_FILL;
            cnt_reg     <= '0;
            bank_reg    <= 1'b0;
            init_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
            iss_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            bank_reg    <= bank_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
            iss_reg     <= iss_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

// ===== test/tb_matrix4_transform_engine.sv =====
// ----------------------------------------------------------------------------
// tb_matrix4_transform_engine
// self-checking bench for the 4x4 fixed-point transform engine: directed
// command sequences, then random commands with random gaps on both sides;
// every result is compared against a behavioral model of both matrices
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix4_transform_engine;
    import mte_pkg::*;

    typedef logic signed [31:0] q16_t;
    typedef q16_t mat_t [16];

    class xform_scoreboard;
        q16_t      cur [16];
        q16_t      opnd [16];
        out_item_t pending_results [$];
        int        mismatches;
        int        checked;

        function new();
            mismatches = 0;
            checked    = 0;
            set_identity(cur);
            foreach (opnd[i]) opnd[i] = '0;
        endfunction

        function void set_identity(ref q16_t m [16]);
            foreach (m[i]) m[i] = '0;
            m[0]  = 32'sd65536;
            m[5]  = 32'sd65536;
            m[10] = 32'sd65536;
            m[15] = 32'sd65536;
        endfunction

        // q61 taylor series of sin, d in 0..90 degrees, rounded to q16.16
        function q16_t sin_quad(int d);
            logic [63:0]  pi_q61;
            logic [63:0]  x;
            logic [63:0]  x2;
            logic [63:0]  term;
            logic [63:0]  s;
            logic [127:0] pr;
            pi_q61 = 64'h6487ED5110B4611A;
            x  = (pi_q61 / 64'd180) * 64'(d) + ((pi_q61 % 64'd180) * 64'(d)) / 64'd180;
            pr = {64'd0, x} * {64'd0, x};
            x2 = pr[124:61];
            term = x;
            s    = x;
            for (int k = 2; k < 40; k += 2) begin
                pr   = {64'd0, term} * {64'd0, x2};
                term = pr[124:61] / 64'(k * (k + 1));
                if (k % 4 == 2) s = s - term;
                else s = s + term;
            end
            s = (s + (64'd1 << 44)) >> 45;
            return q16_t'(s);
        endfunction

        function q16_t sin_of(int a);
            a = a % 360;
            if (a <= 90) return sin_quad(a);
            if (a <= 180) return sin_quad(180 - a);
            if (a <= 270) return -sin_quad(a - 180);
            return -sin_quad(360 - a);
        endfunction

        function void premultiply(q16_t m [16]);
            q16_t               nxt [16];
            logic signed [71:0] acc;
            logic signed [63:0] prod;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    acc = '0;
                    for (int k = 0; k < 4; k++) begin
                        prod = m[r*4+k] * cur[k*4+c];
                        acc  = acc + prod;
                    end
                    acc = acc >>> 16;
                    if (acc > 72'sh7FFFFFFF) nxt[r*4+c] = 32'sh7FFFFFFF;
                    else if (acc < -72'sh80000000) nxt[r*4+c] = 32'sh80000000;
                    else nxt[r*4+c] = acc[31:0];
                end
            end
            cur = nxt;
        endfunction

        function void note_command(in_item_t it);
            q16_t      m [16];
            q16_t      s;
            q16_t      c;
            out_item_t res;
            res = '0;
            case (op_t'(it.op))
                OP_IDENT:      set_identity(cur);
                OP_WRITE_CUR:  cur[it.elem_index] = it.elem_value;
                OP_READ_CUR:   res.read_value = cur[it.elem_index];
                OP_WRITE_OPND: opnd[it.elem_index] = it.elem_value;
                OP_MULTIPLY:   premultiply(opnd);
                OP_TRANSLATE, OP_SCALE: begin
                    set_identity(m);
                    if (it.op == OP_TRANSLATE) begin
                        m[12] = it.coord_x; m[13] = it.coord_y; m[14] = it.coord_z;
                    end else begin
                        m[0] = it.coord_x; m[5] = it.coord_y; m[10] = it.coord_z;
                    end
                    premultiply(m);
                end
                OP_ROTATE: begin
                    if (it.rot_axis == AXIS_BAD) begin
                        res.status = 1'b1;
                    end else begin
                        s = sin_of(it.angle_degrees);
                        c = sin_of(it.angle_degrees + 90);
                        set_identity(m);
                        case (it.rot_axis)
                            AXIS_X: begin
                                m[5] = c; m[6] = -s; m[9] = s; m[10] = c;
                            end
                            AXIS_Y: begin
                                m[0] = c; m[2] = s; m[8] = -s; m[10] = c;
                            end
                            default: begin
                                m[0] = c; m[1] = -s; m[4] = s; m[5] = c;
                            end
                        endcase
                        premultiply(m);
                    end
                end
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_response(out_item_t got);
            out_item_t want;
            checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result value=%h status=%b",
                             $realtime, got.read_value, got.status);
                return;
            end
            want = pending_results.pop_front();
            if (got.read_value !== want.read_value || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp value=%h status=%b got value=%h status=%b",
                             $realtime, want.read_value, want.status,
                             got.read_value, got.status);
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 5000;
    localparam int N_RANDOM   = 1250;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    xform_scoreboard sb;
    int idle_cycles;
    int sent;
    int reads_sent;
    int rotates_sent;

    matrix4_transform_engine u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // small values within +-2.0 half of the time, extremes and raw words otherwise
    function automatic q16_t rand_q16();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return q16_t'($signed($urandom_range(0, 262144)) - 131072);
        if (pick == 5) return 32'sh7FFFFFFF;
        if (pick == 6) return 32'sh80000000;
        return q16_t'($urandom);
    endfunction

    function automatic in_item_t make_cmd(op_t op);
        in_item_t it;
        it.op            = op;
        it.elem_index    = 4'($urandom);
        it.elem_value    = rand_q16();
        it.coord_x       = rand_q16();
        it.coord_y       = rand_q16();
        it.coord_z       = rand_q16();
        it.rot_axis      = 2'($urandom);
        it.angle_degrees = ($urandom_range(0, 7) == 0) ? 9'($urandom)
                                                       : 9'($urandom_range(0, 359));
        return it;
    endfunction

    task automatic send_cmd(in_item_t it);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(it);
        sent++;
        if (it.op == OP_READ_CUR) reads_sent++;
        if (it.op == OP_ROTATE) rotates_sent++;
    endtask

    task automatic send_op(op_t op, int idx, q16_t val);
        in_item_t it;
        it = make_cmd(op);
        it.elem_index = 4'(idx);
        it.elem_value = val;
        send_cmd(it);
    endtask

    task automatic send_rotate(logic [1:0] axis, int ang);
        in_item_t it;
        it = make_cmd(OP_ROTATE);
        it.rot_axis      = axis;
        it.angle_degrees = 9'(ang);
        send_cmd(it);
    endtask

    task automatic run_directed();
        in_item_t it;
        send_op(OP_READ_CUR, 0, 0);
        send_op(OP_READ_CUR, 15, 0);
        send_op(OP_WRITE_CUR, 0, 32'sh7FFFFFFF);
        send_op(OP_WRITE_CUR, 15, 32'sh80000000);
        send_op(OP_READ_CUR, 0, 0);
        send_op(OP_READ_CUR, 15, 0);
        send_op(OP_MULTIPLY, 0, 0);
        send_op(OP_READ_CUR, 5, 0);
        send_op(OP_IDENT, 0, 0);
        send_op(OP_WRITE_OPND, 0, 32'sh7FFFFFFF);
        send_op(OP_WRITE_OPND, 15, 32'sh80000000);
        send_op(OP_MULTIPLY, 0, 0);
        send_op(OP_READ_CUR, 0, 0);
        it = make_cmd(OP_TRANSLATE);
        it.coord_x = 32'sh7FFFFFFF; it.coord_y = 32'sh80000000; it.coord_z = 32'sh00010000;
        send_cmd(it);
        send_op(OP_READ_CUR, 12, 0);
        it = make_cmd(OP_SCALE);
        it.coord_x = 32'sh80000000; it.coord_y = 32'sh7FFFFFFF; it.coord_z = 32'sh0;
        send_cmd(it);
        send_op(OP_IDENT, 0, 0);
        send_rotate(AXIS_X, 90);
        send_rotate(AXIS_Y, 359);
        send_rotate(AXIS_Z, 511);
        send_rotate(AXIS_BAD, 45);
        send_rotate(AXIS_Z, 0);
        send_op(OP_READ_CUR, 1, 0);
        send_op(OP_READ_CUR, 4, 0);
    endtask

    task automatic run_random();
        int pick;
        op_t op;
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 6) op = OP_READ_CUR;
            else if (pick < 8) op = OP_WRITE_CUR;
            else if (pick < 10) op = OP_WRITE_OPND;
            else if (pick < 11) op = OP_IDENT;
            else if (pick < 13) op = OP_TRANSLATE;
            else if (pick < 15) op = OP_SCALE;
            else if (pick < 18) op = OP_ROTATE;
            else op = OP_MULTIPLY;
            send_cmd(make_cmd(op));
        end
    endtask

    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_response(m_item);
        end
    end

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        idle_cycles  = 0;
        sent         = 0;
        reads_sent   = 0;
        rotates_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("sent %0d commands (%0d reads, %0d rotations), checked %0d results",
                 sent, reads_sent, rotates_sent, sb.checked);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mte_pkg.sv
hw/rtl/mte_trig.sv
hw/rtl/mte_mac.sv
hw/rtl/matrix4_transform_engine.sv
test/tb_matrix4_transform_engine.sv
